// ===== rtl/wcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform column decimator package
// Shared types, constants and the constant log2 helper.
// ----------------------------------------------------------------------------
package wcd_pkg;

   localparam int FRAME_SAMPLES_DEF = 256;
   localparam int COLUMN_ROWS_DEF   = 64;
   localparam int PEAK_WINDOW_DEF   = 256;
   localparam int LOG_FACTOR_DEF    = 10;

   localparam int SAMPLE_W  = 16;
   localparam int ROW_W     = 6;
   localparam int GAIN_W    = 16;
   localparam int LOG_FRAC  = 20;
   localparam int LOG_W     = 26;
   localparam int X_W       = 35;
   localparam int Y_W       = 31;
   localparam int MAG_W     = 24;
   localparam int COMP_W    = 16;
   localparam int DIVD_W    = LOG_W + 15;
   localparam int DIVS_W    = LOG_W;
   localparam int MUL_W     = 32;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   localparam logic [GAIN_W-1:0] MAX_GAIN_RESET = 16'd2048;
   localparam logic [GAIN_W-1:0] GAIN_UNITY     = 16'd256;
   localparam logic [MAG_W:0]    UNITY_Q23      = 25'd8388608;
   localparam logic [COMP_W:0]   COMP_MID       = 17'd32768;
   localparam logic [0:0]        CSR_MAX_GAIN   = 1'b0;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PK_ADDR,
      ST_PK_CMP,
      ST_GAIN_DIV,
      ST_GAIN_WAIT,
      ST_ROW,
      ST_SMP_ADDR,
      ST_SMP_MAG,
      ST_SMP_SCALE,
      ST_LOG_BASE,
      ST_NORM,
      ST_SQ_MUL,
      ST_SQ_RED,
      ST_CDIV,
      ST_CDIV_WAIT,
      ST_CDIV_FIX,
      ST_LVL_MUL,
      ST_LVL_UPD
   } wcd_state_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVS_W-1:0] divisor;
   } wcd_div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVD_W-1:0] quotient;
   } wcd_div_rsp_type;

   function automatic logic [LOG_W-1:0] log2_q20(input logic [63:0] x);
      logic [5:0]  n;
      logic [63:0] y;
      logic [19:0] frac;
      n    = '0;
      frac = '0;
      for (int b = 1; b < 64; b++) begin
         if ((x >> b) != 64'd0) begin
            n = b[5:0];
         end
      end
      if (n <= 6'd30) begin
         y = x << (6'd30 - n);
      end else begin
         y = x >> (n - 6'd30);
      end
      for (int k = 0; k < LOG_FRAC; k++) begin
         y    = (y * y) >> 30;
         frac = {frac[18:0], 1'b0};
         if (y >= 64'h8000_0000) begin
            y       = y >> 1;
            frac[0] = 1'b1;
         end
      end
      return {n, frac};
   endfunction

endpackage

// ===== rtl/wcd_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32 x 32 multiply with a registered product.
// ----------------------------------------------------------------------------
module wcd_mul
   import wcd_pkg::*;
(
   input  logic               clock,
   input  logic [MUL_W-1:0]   mul_a,
   input  logic [MUL_W-1:0]   mul_b,
   output logic [2*MUL_W-1:0] mul_p
);

   logic [2*MUL_W-1:0] prod_ff;
   logic [2*MUL_W-1:0] prod_in;

   assign prod_in = mul_a * mul_b;
   assign mul_p   = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== rtl/wcd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wcd_div
   import wcd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  wcd_div_req_type div_req,
   output wcd_div_rsp_type div_rsp
);

   localparam int CW = $clog2(DIVD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVS_W-1:0] dvs_ff, dvs_in;
   logic [DIVS_W:0]   trial;
   logic [DIVS_W:0]   diff;
   logic              ge;

   assign trial = {rem_ff, quo_ff[DIVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
         quo_in = {quo_ff[DIVD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/waveform_column_min_max_decimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform column min/max decimator
// Frame buffer, windowed peak, auto gain, log companding and per-row
// min/max levels for one display column.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with req_sample while busy is low to hand in one item.
//   Items that do not complete a frame are taken at once and busy
//   stays low, so such items can follow back to back.
//   The item that fills the frame starts a column: a peak scan over the
//   peak window (an address and a compare step per entry), a gain division
//   (skipped when the peak is zero), then a setup step per row and, for each
//   sample of its span, a scale on the shared multiplier, up to 12 normalize
//   steps, 20 log squaring steps and a reciprocal multiply for the log ratio.
//   Each row emits one item on the rsp_ ports, valid for exactly one cycle
//   with rsp_valid; rsp_last marks the final row. The receiver cannot
//   stall; the block stays busy until the last row is out.
//   After reset the peak ring is cleared, one entry per cycle, with busy
//   high. The user must write max_gain over the APB port only while the
//   block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module waveform_column_min_max_decimator
   import wcd_pkg::*;
#(
   parameter int FRAME_SAMPLES = FRAME_SAMPLES_DEF,
   parameter int COLUMN_ROWS   = COLUMN_ROWS_DEF,
   parameter int PEAK_WINDOW   = PEAK_WINDOW_DEF,
   parameter int LOG_FACTOR    = LOG_FACTOR_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [SAMPLE_W-1:0] req_sample,
   output logic                rsp_valid,
   output logic [ROW_W-1:0]    rsp_row_index,
   output logic [ROW_W-1:0]    rsp_low_row,
   output logic [ROW_W-1:0]    rsp_high_row,
   output logic                rsp_last,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready
);

   localparam int FW     = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
   localparam int PW     = (PEAK_WINDOW > 1) ? $clog2(PEAK_WINDOW) : 1;
   localparam int BW     = $clog2(FRAME_SAMPLES + 1);
   localparam int RW     = $clog2(COLUMN_ROWS) + 1;
   localparam int Q_STEP = FRAME_SAMPLES / COLUMN_ROWS;
   localparam int R_STEP = FRAME_SAMPLES % COLUMN_ROWS;
   localparam bit LOG_ON = (LOG_FACTOR > 1);
   localparam logic [LOG_W-1:0] LF = log2_q20(64'(LOG_FACTOR));
   localparam logic [LOG_W-1:0] LOG_OFFSET = LOG_W'(23 << LOG_FRAC);
   localparam logic [MUL_W-1:0] LF_RECIP =
      MUL_W'((64'd1 << DIVD_W) / ((LF == '0) ? 64'd1 : 64'(LF)));

   wcd_state_type state_ff, state_in;

   logic [FW-1:0]       fpos_ff, fpos_in;
   logic [PW-1:0]       ppos_ff, ppos_in;
   logic [PW-1:0]       rcnt_ff, rcnt_in;
   logic [GAIN_W-1:0]   max_gain_ff, max_gain_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [SAMPLE_W-1:0] peak_ff, peak_in;
   logic [GAIN_W-1:0]   gain_ff, gain_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [BW-1:0]       bnd_ff, bnd_in;
   logic [RW-1:0]       rem_ff, rem_in;
   logic [BW-1:0]       idx_ff, idx_in;
   logic [BW-1:0]       end_ff, end_in;
   logic                first_ff, first_in;
   logic                neg_ff, neg_in;
   logic [X_W-1:0]      x_ff, x_in;
   logic [5:0]          n_ff, n_in;
   logic [Y_W-1:0]      y_ff, y_in;
   logic [LOG_FRAC-1:0] frac_ff, frac_in;
   logic [4:0]          k_ff, k_in;
   logic [MUL_W-1:0]    cq_ff, cq_in;
   logic [COMP_W-1:0]   c_ff, c_in;
   logic [ROW_W-1:0]    lo_ff, lo_in;
   logic [ROW_W-1:0]    hi_ff, hi_in;
   logic [ROW_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [ROW_W-1:0]    rsp_lo_ff, rsp_lo_in;
   logic [ROW_W-1:0]    rsp_hi_ff, rsp_hi_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [SAMPLE_W-1:0] frame_mem [FRAME_SAMPLES];
   logic [SAMPLE_W-1:0] frame_rd_ff;
   logic [SAMPLE_W-1:0] ring_mem [PEAK_WINDOW];
   logic [SAMPLE_W-1:0] ring_rd_ff;

   logic                accept;
   logic                ring_we;
   logic [PW-1:0]       ring_wa;
   logic [SAMPLE_W-1:0] ring_wd;
   logic [SAMPLE_W-1:0] req_mag;
   logic [SAMPLE_W-1:0] rd_mag;
   logic                cfg_wr;

   logic [MUL_W-1:0]    mul_a, mul_b;
   logic [2*MUL_W-1:0]  mul_p;
   wcd_div_req_type     div_req;
   wcd_div_rsp_type     div_rsp;

   logic [RW:0]         rem_sum;
   logic                rem_carry;
   logic [BW-1:0]       bnd_next;
   logic [MAG_W-1:0]    m_sat;
   logic [31:0]         sq_t;
   logic [LOG_W-1:0]    log_num;
   logic [DIVD_W-1:0]   c_rem;
   logic [MUL_W-1:0]    c_quo;
   logic [COMP_W:0]     lvl_val;
   logic [ROW_W-1:0]    lvl;
   logic [ROW_W-1:0]    lo_new, hi_new;

   wcd_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   wcd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign req_mag = req_sample[SAMPLE_W-1] ? SAMPLE_W'(~req_sample + 1'b1) : req_sample;
   assign rd_mag  = frame_rd_ff[SAMPLE_W-1] ? SAMPLE_W'(~frame_rd_ff + 1'b1) : frame_rd_ff;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite && (paddr[2] == CSR_MAX_GAIN);
   assign prdata  = (paddr[2] == CSR_MAX_GAIN) ? DATA_W'(max_gain_ff) : '0;
   assign max_gain_in = cfg_wr ? pwdata[GAIN_W-1:0] : max_gain_ff;

   assign rem_sum   = (RW+1)'(rem_ff) + (RW+1)'(R_STEP);
   assign rem_carry = rem_sum >= (RW+1)'(COLUMN_ROWS);
   assign bnd_next  = bnd_ff + BW'(Q_STEP) + BW'(rem_carry);

   assign m_sat   = (mul_p > 64'(UNITY_Q23)) ? UNITY_Q23[MAG_W-1:0] + MAG_W'(0) : mul_p[MAG_W-1:0];
   assign sq_t    = mul_p[61:30];
   assign log_num = {n_ff, frac_ff} - LOG_OFFSET;
   assign c_rem   = {log_num, 15'b0} - mul_p[DIVD_W-1:0];
   assign c_quo   = cq_ff + MUL_W'(c_rem >= DIVD_W'(LF));
   assign lvl_val = neg_ff ? COMP_MID - {1'b0, c_ff} : COMP_MID + {1'b0, c_ff};
   assign lvl     = mul_p[21:16];
   assign lo_new  = (first_ff || lvl < lo_ff) ? lvl : lo_ff;
   assign hi_new  = (first_ff || lvl > hi_ff) ? lvl : hi_ff;

   always_comb begin
      state_in     = state_ff;
      fpos_in      = fpos_ff;
      ppos_in      = ppos_ff;
      rcnt_in      = rcnt_ff;
      rsp_valid_in = 1'b0;
      peak_in      = peak_ff;
      gain_in      = gain_ff;
      row_in       = row_ff;
      bnd_in       = bnd_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      end_in       = end_ff;
      first_in     = first_ff;
      neg_in       = neg_ff;
      x_in         = x_ff;
      n_in         = n_ff;
      y_in         = y_ff;
      frac_in      = frac_ff;
      k_in         = k_ff;
      cq_in        = cq_ff;
      c_in         = c_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_lo_in    = rsp_lo_ff;
      rsp_hi_in    = rsp_hi_ff;
      rsp_last_in  = rsp_last_ff;
      ring_we      = 1'b0;
      ring_wa      = ppos_ff;
      ring_wd      = req_mag;
      mul_a        = '0;
      mul_b        = '0;
      div_req      = '0;
      case (state_ff)
         ST_CLEAR: begin
            ring_we = 1'b1;
            ring_wa = rcnt_ff;
            ring_wd = '0;
            rcnt_in = rcnt_ff + 1'b1;
            if (rcnt_ff == PW'(PEAK_WINDOW - 1)) begin
               rcnt_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               ring_we = 1'b1;
               ppos_in = (ppos_ff == PW'(PEAK_WINDOW - 1)) ? '0 : ppos_ff + 1'b1;
               fpos_in = fpos_ff + 1'b1;
               if (fpos_ff == FW'(FRAME_SAMPLES - 1)) begin
                  fpos_in  = '0;
                  rcnt_in  = '0;
                  peak_in  = '0;
                  row_in   = '0;
                  bnd_in   = '0;
                  rem_in   = '0;
                  state_in = ST_PK_ADDR;
               end
            end
         end
         ST_PK_ADDR: begin
            state_in = ST_PK_CMP;
         end
         ST_PK_CMP: begin
            if (ring_rd_ff > peak_ff) begin
               peak_in = ring_rd_ff;
            end
            rcnt_in  = rcnt_ff + 1'b1;
            state_in = ST_PK_ADDR;
            if (rcnt_ff == PW'(PEAK_WINDOW - 1)) begin
               rcnt_in  = '0;
               state_in = ST_GAIN_DIV;
            end
         end
         ST_GAIN_DIV: begin
            if (peak_ff == '0) begin
               gain_in  = GAIN_UNITY;
               state_in = ST_ROW;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIVD_W'(UNITY_Q23);
               div_req.divisor  = DIVS_W'(peak_ff);
               state_in         = ST_GAIN_WAIT;
            end
         end
         ST_GAIN_WAIT: begin
            if (div_rsp.done) begin
               gain_in  = (div_rsp.quotient > DIVD_W'(max_gain_ff)) ?
                          max_gain_ff : div_rsp.quotient[GAIN_W-1:0];
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            idx_in   = bnd_ff;
            end_in   = (bnd_next <= bnd_ff) ? bnd_ff + 1'b1 : bnd_next;
            bnd_in   = bnd_next;
            rem_in   = rem_carry ? RW'(rem_sum - (RW+1)'(COLUMN_ROWS)) : RW'(rem_sum);
            first_in = 1'b1;
            state_in = ST_SMP_ADDR;
         end
         ST_SMP_ADDR: begin
            state_in = ST_SMP_MAG;
         end
         ST_SMP_MAG: begin
            neg_in   = frame_rd_ff[SAMPLE_W-1];
            mul_a    = MUL_W'(rd_mag);
            mul_b    = MUL_W'(gain_ff);
            state_in = ST_SMP_SCALE;
         end
         ST_SMP_SCALE: begin
            if (LOG_ON) begin
               mul_a    = MUL_W'(m_sat);
               mul_b    = MUL_W'(LOG_FACTOR - 1);
               state_in = ST_LOG_BASE;
            end else begin
               c_in     = COMP_W'(m_sat >> 8);
               state_in = ST_LVL_MUL;
            end
         end
         ST_LOG_BASE: begin
            x_in     = X_W'(UNITY_Q23) + mul_p[X_W-1:0];
            n_in     = 6'(X_W - 1);
            state_in = ST_NORM;
         end
         ST_NORM: begin
            if (x_ff[X_W-1]) begin
               y_in     = x_ff[X_W-1:X_W-Y_W];
               frac_in  = '0;
               k_in     = '0;
               state_in = ST_SQ_MUL;
            end else begin
               x_in = {x_ff[X_W-2:0], 1'b0};
               n_in = n_ff - 1'b1;
            end
         end
         ST_SQ_MUL: begin
            mul_a    = MUL_W'(y_ff);
            mul_b    = MUL_W'(y_ff);
            state_in = ST_SQ_RED;
         end
         ST_SQ_RED: begin
            y_in     = sq_t[31] ? sq_t[31:1] : sq_t[30:0];
            frac_in  = {frac_ff[LOG_FRAC-2:0], sq_t[31]};
            k_in     = k_ff + 1'b1;
            state_in = (k_ff == 5'(LOG_FRAC - 1)) ? ST_CDIV : ST_SQ_MUL;
         end
         ST_CDIV: begin
            mul_a    = MUL_W'(log_num);
            mul_b    = LF_RECIP;
            state_in = ST_CDIV_WAIT;
         end
         ST_CDIV_WAIT: begin
            cq_in    = mul_p[LOG_W +: MUL_W];
            mul_a    = mul_p[LOG_W +: MUL_W];
            mul_b    = MUL_W'(LF);
            state_in = ST_CDIV_FIX;
         end
         ST_CDIV_FIX: begin
            c_in     = (c_quo > MUL_W'(COMP_MID)) ?
                       COMP_MID[COMP_W-1:0] : c_quo[COMP_W-1:0];
            state_in = ST_LVL_MUL;
         end
         ST_LVL_MUL: begin
            mul_a    = MUL_W'(lvl_val);
            mul_b    = MUL_W'(COLUMN_ROWS - 1);
            state_in = ST_LVL_UPD;
         end
         ST_LVL_UPD: begin
            lo_in    = lo_new;
            hi_in    = hi_new;
            first_in = 1'b0;
            if (BW'(idx_ff + 1'b1) == end_ff) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_ff;
               rsp_lo_in    = lo_new;
               rsp_hi_in    = hi_new;
               rsp_last_in  = (row_ff == ROW_W'(COLUMN_ROWS - 1));
               row_in       = row_ff + 1'b1;
               state_in     = (row_ff == ROW_W'(COLUMN_ROWS - 1)) ? ST_IDLE : ST_ROW;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SMP_ADDR;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         fpos_ff      <= '0;
         ppos_ff      <= '0;
         rcnt_ff      <= '0;
         max_gain_ff  <= MAX_GAIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fpos_ff      <= fpos_in;
         ppos_ff      <= ppos_in;
         rcnt_ff      <= rcnt_in;
         max_gain_ff  <= max_gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      peak_ff     <= peak_in;
      gain_ff     <= gain_in;
      row_ff      <= row_in;
      bnd_ff      <= bnd_in;
      rem_ff      <= rem_in;
      idx_ff      <= idx_in;
      end_ff      <= end_in;
      first_ff    <= first_in;
      neg_ff      <= neg_in;
      x_ff        <= x_in;
      n_ff        <= n_in;
      y_ff        <= y_in;
      frac_ff     <= frac_in;
      k_ff        <= k_in;
      cq_ff       <= cq_in;
      c_ff        <= c_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_lo_ff   <= rsp_lo_in;
      rsp_hi_ff   <= rsp_hi_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         frame_mem[fpos_ff] <= req_sample;
      end
      frame_rd_ff <= frame_mem[idx_ff[FW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_wa] <= ring_wd;
      end
      ring_rd_ff <= ring_mem[rcnt_ff];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = rsp_row_ff;
   assign rsp_low_row   = rsp_lo_ff;
   assign rsp_high_row  = rsp_hi_ff;
   assign rsp_last      = rsp_last_ff;

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_low_row <= rsp_high_row))
      else $error("low row above high row");

   a_last_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_row_index == ROW_W'(COLUMN_ROWS - 1)))
      else $error("last flag on wrong row");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("block still busy after last row");

   a_no_emit_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (state_ff == ST_ROW))
      else $error("row item outside column walk");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_GAIN_WAIT || state_ff == ST_CDIV_WAIT))
      else $error("divider result with no waiter");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform column decimator testbench
// Feeds audio samples through the command port in random bursts and
// compares every emitted row min/max item with a local column predictor.
// The max_gain register is changed over APB while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
   import wcd_pkg::*;

   localparam int NFRAME = FRAME_SAMPLES_DEF;
   localparam int NROWS  = COLUMN_ROWS_DEF;
   localparam int NPEAK  = PEAK_WINDOW_DEF;
   localparam int LFAC   = LOG_FACTOR_DEF;

   typedef struct packed {
      logic [ROW_W-1:0] row_index;
      logic [ROW_W-1:0] low_row;
      logic [ROW_W-1:0] high_row;
      logic             last;
   } row_span_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic                rsp_valid;
   logic [ROW_W-1:0]    rsp_row_index;
   logic [ROW_W-1:0]    rsp_low_row;
   logic [ROW_W-1:0]    rsp_high_row;
   logic                rsp_last;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   logic signed [SAMPLE_W-1:0] col_frame [NFRAME];
   logic [SAMPLE_W-1:0]        col_peaks [NPEAK];
   int                         col_fpos;
   int                         col_ppos;
   logic [GAIN_W-1:0]          col_max_gain;
   row_span_type               pending_rows [$];
   int                         errors = 0;

   logic signed [SAMPLE_W-1:0] directed_samples [20] = '{
      16'sh0000, 16'sh7FFF, -16'sh8000, 16'sh0001, -16'sh0001,
      16'sh4000, -16'sh4000, 16'sh5555, 16'shAAAA, 16'sh00FF,
      16'shFF00, 16'sh0100, -16'sh0100, 16'sh7FFE, -16'sh7FFF,
      16'sh1234, 16'shEDCB, 16'sh0F0F, 16'shF0F0, 16'sh0000
   };

   waveform_column_min_max_decimator DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_sample(req_sample), .rsp_valid(rsp_valid),
      .rsp_row_index(rsp_row_index), .rsp_low_row(rsp_low_row),
      .rsp_high_row(rsp_high_row), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   function automatic logic [63:0] log2_fixed(input logic [63:0] x);
      int          msb;
      logic [63:0] y;
      logic [63:0] frac;
      msb  = 0;
      frac = 0;
      for (int b = 0; b < 64; b++) begin
         if (x[b]) msb = b;
      end
      y = (msb <= 30) ? (x << (30 - msb)) : (x >> (msb - 30));
      for (int k = 0; k < LOG_FRAC; k++) begin
         y    = (y * y) >> 30;
         frac = frac << 1;
         if (y >= 64'h8000_0000) begin
            y    = y >> 1;
            frac = frac | 1;
         end
      end
      return (64'(msb) << LOG_FRAC) | frac;
   endfunction

   function automatic int level_of(input logic signed [SAMPLE_W-1:0] s,
                                   input logic [31:0] gain);
      logic [63:0] mag;
      logic [63:0] m;
      logic [63:0] num;
      logic [63:0] c;
      int          cs;
      mag = (s < 0) ? 64'(-32'(s)) : 64'(s);
      m   = mag * gain;
      if (m > 64'd8388608) m = 64'd8388608;
      if (LFAC <= 1) begin
         c = m >> 8;
      end else begin
         num = log2_fixed(64'd8388608 + m * (LFAC - 1)) - (64'd23 << LOG_FRAC);
         c   = (num << 15) / log2_fixed(64'(LFAC));
         if (c > 64'd32768) c = 64'd32768;
      end
      cs = (s < 0) ? -int'(c) : int'(c);
      return ((cs + 32768) * (NROWS - 1)) >>> 16;
   endfunction

   task automatic predict_column(input logic signed [SAMPLE_W-1:0] s);
      int           peak;
      logic [31:0]  gain;
      int           lo;
      int           hi;
      int           y;
      int           sp_start;
      int           sp_end;
      row_span_type rs;
      col_frame[col_fpos] = s;
      col_peaks[col_ppos] = (s < 0) ? SAMPLE_W'(-32'(s)) : SAMPLE_W'(s);
      col_ppos = (col_ppos + 1) % NPEAK;
      col_fpos++;
      if (col_fpos < NFRAME) return;
      col_fpos = 0;
      peak = 0;
      for (int i = 0; i < NPEAK; i++) begin
         if (col_peaks[i] > peak) peak = col_peaks[i];
      end
      gain = 256;
      if (peak > 0) begin
         gain = 8388608 / peak;
         if (gain > col_max_gain) gain = col_max_gain;
      end
      for (int r = 0; r < NROWS; r++) begin
         sp_start = (r * NFRAME) / NROWS;
         sp_end   = ((r + 1) * NFRAME) / NROWS;
         if (sp_end <= sp_start) sp_end = sp_start + 1;
         if (sp_end > NFRAME) sp_end = NFRAME;
         lo = level_of(col_frame[sp_start], gain);
         hi = lo;
         for (int i = sp_start; i < sp_end; i++) begin
            y = level_of(col_frame[i], gain);
            if (y < lo) lo = y;
            if (y > hi) hi = y;
         end
         rs.row_index = ROW_W'(r);
         rs.low_row   = ROW_W'(lo);
         rs.high_row  = ROW_W'(hi);
         rs.last      = (r == NROWS - 1);
         pending_rows.push_back(rs);
      end
   endtask

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit hold);
      start      <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (busy);
      predict_column(s);
      if (!hold) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic csr_access(input bit wr, input logic [DATA_W-1:0] wdata,
                             output logic [DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= ADDR_W'({CSR_MAX_GAIN, 2'b00});
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata   = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic set_max_gain(input logic [GAIN_W-1:0] g);
      logic [DATA_W-1:0] rd;
      wait_idle();
      csr_access(1'b1, DATA_W'(g), rd);
      col_max_gain = g;
      @(posedge clock);
      csr_access(1'b0, '0, rd);
      if (rd[GAIN_W-1:0] !== g) begin
         $display("%0t max_gain readback expected %0d actual %0d", $time, g,
                  rd[GAIN_W-1:0]);
         errors++;
      end
   endtask

   function automatic logic signed [SAMPLE_W-1:0] gen_sample(input int mode);
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return 16'sh7FFF;
      if (pick == 1) return -16'sh8000;
      case (mode)
         0: return SAMPLE_W'($urandom);
         1: return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
         2: return 16'sh0000;
         default: return SAMPLE_W'($urandom) >>> $urandom_range(0, 12);
      endcase
   endfunction

   task automatic send_frame(input int mode, input int count);
      int burst;
      int sent;
      logic signed [SAMPLE_W-1:0] s;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (int b = 0; b < burst && sent < count; b++) begin
            s = (mode == 2) ? 16'sh0000 : gen_sample(mode);
            sent++;
            send_sample(s, (b < burst - 1) && (sent < count));
         end
         if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      row_span_type want;
      if (!reset && rsp_valid) begin
         if (pending_rows.size() == 0) begin
            $display("%0t unexpected row item row=%0d lo=%0d hi=%0d last=%0d", $time,
                     rsp_row_index, rsp_low_row, rsp_high_row, rsp_last);
            errors++;
         end else begin
            want = pending_rows.pop_front();
            if (rsp_row_index !== want.row_index || rsp_low_row !== want.low_row ||
                rsp_high_row !== want.high_row || rsp_last !== want.last) begin
               $display("%0t mismatch expected row=%0d lo=%0d hi=%0d last=%0d actual row=%0d lo=%0d hi=%0d last=%0d",
                        $time, want.row_index, want.low_row, want.high_row, want.last,
                        rsp_row_index, rsp_low_row, rsp_high_row, rsp_last);
               errors++;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("testbench NOT OK");
      $finish;
   end

   initial begin
      col_fpos     = 0;
      col_ppos     = 0;
      col_max_gain = MAX_GAIN_RESET;
      for (int i = 0; i < NPEAK; i++) col_peaks[i] = '0;
      for (int i = 0; i < NFRAME; i++) col_frame[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // partial frame after reset: no rows due
      foreach (directed_samples[i]) begin
         send_sample(directed_samples[i], $urandom_range(0, 1));
      end
      if (pending_rows.size() != 0) begin
         $display("%0t expected 0 row items actual %0d", $time, pending_rows.size());
         errors++;
      end
      send_frame(3, 100);
      set_max_gain(16'($urandom_range(0, 300)));
      send_frame(1, NFRAME - 120);
      set_max_gain(16'hFFFF);
      send_frame(0, 174);
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
